### hdl/msort_pkg.sv
// msort_pkg: shared constants and controller/datapath command and status types
// for the merge sorter. No dependencies.
package msort_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    typedef struct packed {
        logic load;      // store input beat (or flag drop)
        logic setup;     // start a merge pass or the emission
        logic merge;     // move one element to the other bank
        logic emit_adv;  // output beat taken
        logic clear;     // set done, back to empty
    } t_cmd;

    typedef struct packed {
        logic sort_done;  // run width covers the whole set
        logic pass_end;   // this merge step writes the last element of the pass
        logic emit_last;  // output element is the final one
    } t_status;

endpackage

### hdl/msort_ctrl.sv
// msort_ctrl: sequencer for load, merge passes and emission.
// Depends on msort_pkg; drives msort_dp through t_cmd, reads t_status.
module msort_ctrl
    import msort_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_MERGE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_ready     = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_status.sort_done ? S_EMIT : S_MERGE;
            end
            S_MERGE: begin
                o_cmd.merge = 1'b1;
                if (i_status.pass_end) begin
                    n_state = S_SETUP;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit_adv = 1'b1;
                    if (i_status.emit_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/msort_dp.sv
// msort_dp: two ping-pong element banks, run pointers and merge compare.
// Depends on msort_pkg; commanded by msort_ctrl.
module msort_dp
    import msort_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    output t_status                  o_status,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_last_out,
    output logic                     o_overflow
);

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int W_W    = CNT_W + 1;
    localparam int SUM_W  = CNT_W + 2;

    logic [DATA_W-1:0] r_mem0 [MAX_ITEMS];
    logic [DATA_W-1:0] r_mem1 [MAX_ITEMS];
    logic [DATA_W-1:0] r_a0, r_b0, r_a1, r_b1;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_drop, n_drop;
    logic             r_src, n_src;
    logic [W_W-1:0]   r_w, n_w;
    logic [CNT_W-1:0] r_i, n_i, r_j, n_j, r_ea, n_ea, r_eb, n_eb, r_k, n_k;

    logic signed [DATA_W-1:0] da, db, mdata;
    logic                     take_a, blk_end;
    logic [SUM_W-1:0]         lo_sum_a, lo_sum_b;
    logic [CNT_W-1:0]         lo;

    logic              we0, we1;
    logic [ADDR_W-1:0] wa0;
    logic [DATA_W-1:0] wd0;

    function automatic logic [CNT_W-1:0] clamp_n(input logic [SUM_W-1:0] x,
                                                 input logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] nx;
        nx = {2'b00, n};
        return (x < nx) ? x[CNT_W-1:0] : n;
    endfunction

    assign da     = r_src ? r_a1 : r_a0;
    assign db     = r_src ? r_b1 : r_b0;
    assign take_a = (r_i < r_ea) && ((r_j >= r_eb) || (da <= db));
    assign mdata  = take_a ? da : db;
    assign blk_end = ((r_k + CNT_W'(1)) == r_eb);

    // start of the next block pair: zero on setup, else end of current block
    assign lo       = i_cmd.setup ? '0 : r_eb;
    assign lo_sum_a = {2'b00, lo} + {1'b0, r_w};
    assign lo_sum_b = {2'b00, lo} + {r_w, 1'b0};

    always_comb begin
        n_count = r_count;
        n_drop  = r_drop;
        n_src   = r_src;
        n_w     = r_w;
        n_i     = r_i;
        n_j     = r_j;
        n_ea    = r_ea;
        n_eb    = r_eb;
        n_k     = r_k;
        if (i_cmd.load) begin
            if (r_count < CNT_W'(MAX_ITEMS)) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_drop = 1'b1;
            end
        end
        if (i_cmd.setup) begin
            n_i = '0;
            if (!o_status.sort_done) begin
                n_ea = clamp_n(lo_sum_a, r_count);
                n_j  = clamp_n(lo_sum_a, r_count);
                n_eb = clamp_n(lo_sum_b, r_count);
                n_k  = '0;
            end
        end
        if (i_cmd.merge) begin
            n_k = r_k + CNT_W'(1);
            if (take_a) begin
                n_i = r_i + CNT_W'(1);
            end else begin
                n_j = r_j + CNT_W'(1);
            end
            if (blk_end) begin
                if (r_eb == r_count) begin
                    n_w   = {r_w[W_W-2:0], 1'b0};
                    n_src = ~r_src;
                end else begin
                    n_i  = lo;
                    n_ea = clamp_n(lo_sum_a, r_count);
                    n_j  = clamp_n(lo_sum_a, r_count);
                    n_eb = clamp_n(lo_sum_b, r_count);
                end
            end
        end
        if (i_cmd.emit_adv) begin
            n_i = r_i + CNT_W'(1);
        end
        if (i_cmd.clear) begin
            n_count = '0;
            n_drop  = 1'b0;
            n_src   = 1'b0;
            n_w     = W_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
            r_src   <= 1'b0;
            r_w     <= W_W'(1);
            r_i     <= '0;
            r_j     <= '0;
            r_ea    <= '0;
            r_eb    <= '0;
            r_k     <= '0;
        end else begin
            r_count <= n_count;
            r_drop  <= n_drop;
            r_src   <= n_src;
            r_w     <= n_w;
            r_i     <= n_i;
            r_j     <= n_j;
            r_ea    <= n_ea;
            r_eb    <= n_eb;
            r_k     <= n_k;
        end
    end

    // bank 0 takes loads and the merges that read bank 1, bank 1 the merges that read bank 0
    assign we0 = (i_cmd.load && (r_count < CNT_W'(MAX_ITEMS))) || (i_cmd.merge && r_src);
    assign wa0 = i_cmd.load ? r_count[ADDR_W-1:0] : r_k[ADDR_W-1:0];
    assign wd0 = i_cmd.load ? i_value : mdata;
    assign we1 = i_cmd.merge && !r_src;

    always_ff @(posedge i_clk) begin
        if (we0) begin
            r_mem0[wa0] <= wd0;
        end
        r_a0 <= r_mem0[n_i[ADDR_W-1:0]];
        r_b0 <= r_mem0[n_j[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            r_mem1[r_k[ADDR_W-1:0]] <= mdata;
        end
        r_a1 <= r_mem1[n_i[ADDR_W-1:0]];
        r_b1 <= r_mem1[n_j[ADDR_W-1:0]];
    end

    assign o_status.sort_done = (r_w >= {1'b0, r_count});
    assign o_status.pass_end  = blk_end && (r_eb == r_count);
    assign o_status.emit_last = (r_i == (r_count - CNT_W'(1)));

    assign o_sorted_value = da;
    assign o_last_out     = o_status.emit_last;
    assign o_overflow     = r_drop;

endmodule

### hdl/merge_sorter.sv
// merge_sorter: top level, collects a set of signed words and returns it sorted.
// Depends on msort_pkg, msort_ctrl and msort_dp.
//
// Input beats are taken one per cycle while the block collects a set; the beat
// with i_last high closes the set and starts the sort. Up to MAX_ITEMS values are
// kept; beats beyond that are dropped and o_overflow is high on every output beat
// of that set. The sort is a bottom-up merge over two banks of MAX_ITEMS words:
// each pass moves one element per cycle through a single compare, with
// ceil(log2(n)) passes for n stored values, each opened by a setup step, and one
// more setup step before the output. The set then leaves at one beat per cycle while
// i_ready is high, ascending, o_last_out on the final beat. No new input is taken
// from the closing beat until the final output beat.
module merge_sorter
    import msort_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_sorted_value,
    output logic                     o_last_out,
    output logic                     o_overflow
);

    t_cmd    cmd;
    t_status status;

    msort_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last      (i_last),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_ready     (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    msort_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_value),
        .o_status       (status),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

endmodule
